// ===== sv/rist_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rist_pkg
// Shared widths, codes and types of the refcounted inode slot table.
// ----------------------------------------------------------------------------
package rist_pkg;

  localparam int unsigned DEV_W  = 16;
  localparam int unsigned NUM_W  = 32;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned KEY_W  = DEV_W + NUM_W;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_CLAIMED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_ZERO     = 3'd3,
    ST_RELEASED = 3'd4,
    ST_WAS_FREE = 3'd5,
    ST_BAD      = 3'd6
  } rist_status_e;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    rist_status_e      status;
    logic              read_request;
    logic              write_request;
    logic [CNT_W-1:0]  count;
  } rist_result_t;

endpackage
`default_nettype wire

// ===== sv/rist_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rist_ram
// Simple dual-port synchronous ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module rist_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/rist_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rist_ctrl
// Sequencer: clearing pass, slot scan for acquire, read-modify-write for
// release, one result per item.
// ----------------------------------------------------------------------------
module rist_ctrl #(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          kind_i,
  input  wire logic [rist_pkg::DEV_W-1:0]    device_i,
  input  wire logic [rist_pkg::NUM_W-1:0]    inode_number_i,
  input  wire logic [rist_pkg::SLOT_W-1:0]   slot_i,
  input  wire logic                          slot_given_i,
  input  wire logic [rist_pkg::DEV_W-1:0]    no_dev_i,
  output logic                               res_valid_o,
  output rist_pkg::rist_result_t             res_o,
  input  wire logic                          res_take_i,
  output logic                               cnt_we_o,
  output logic [$clog2(SLOT_COUNT)-1:0]      cnt_waddr_o,
  output logic [rist_pkg::CNT_W-1:0]         cnt_wdata_o,
  output logic [$clog2(SLOT_COUNT)-1:0]      raddr_o,
  input  wire logic [rist_pkg::CNT_W-1:0]    cnt_rdata_i,
  output logic                               key_we_o,
  output logic [rist_pkg::KEY_W-1:0]         key_wdata_o,
  input  wire logic [rist_pkg::KEY_W-1:0]    key_rdata_i
);

  localparam int unsigned IW = $clog2(SLOT_COUNT);
  localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);
  localparam logic [31:0] SLOTS_32 = 32'(SLOT_COUNT);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_REL   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [IW-1:0]               addr_q, addr_d;
  logic [IW-1:0]               prev_q, prev_d;
  logic                        free_q, free_d;
  logic [IW-1:0]               free_idx_q, free_idx_d;
  logic [rist_pkg::DEV_W-1:0]  dev_q, dev_d;
  logic [rist_pkg::NUM_W-1:0]  num_q, num_d;
  logic [rist_pkg::SLOT_W-1:0] slot_q, slot_d;
  rist_pkg::rist_result_t      res_q, res_d;

  logic [IW+rist_pkg::SLOT_W-1:0] slot_ext;
  logic [IW-1:0]                  slot_addr;
  logic                           slot_oob;
  logic [IW+rist_pkg::SLOT_W-1:0] prev_ext;
  logic [IW+rist_pkg::SLOT_W-1:0] claim_ext;
  logic                           hit;
  logic                           free_now;
  logic [IW-1:0]                  claim_idx;
  logic [rist_pkg::CNT_W-1:0]     cnt_inc;
  logic [rist_pkg::CNT_W-1:0]     cnt_dec;

  assign slot_ext  = {{IW{1'b0}}, slot_i};
  assign slot_addr = slot_ext[IW-1:0];
  assign slot_oob  = {{(32 - rist_pkg::SLOT_W){1'b0}}, slot_i} >= SLOTS_32;

  // rdata belongs to slot prev_q while scanning
  assign hit       = (cnt_rdata_i != '0) && (key_rdata_i == {dev_q, num_q});
  assign free_now  = free_q || (cnt_rdata_i == '0);
  assign claim_idx = (cnt_rdata_i == '0) ? prev_q : free_idx_q;
  assign prev_ext  = {{rist_pkg::SLOT_W{1'b0}}, prev_q};
  assign claim_ext = {{rist_pkg::SLOT_W{1'b0}}, claim_idx};
  assign cnt_inc   = (cnt_rdata_i == rist_pkg::CNT_MAX) ? cnt_rdata_i
                                                        : cnt_rdata_i + 1'b1;
  assign cnt_dec   = cnt_rdata_i - 1'b1;

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    prev_d      = prev_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    dev_d       = dev_q;
    num_d       = num_q;
    slot_d      = slot_q;
    res_d       = res_q;
    raddr_o     = addr_q;
    cnt_we_o    = 1'b0;
    cnt_waddr_o = addr_q;
    cnt_wdata_o = '0;
    key_we_o    = 1'b0;
    key_wdata_o = {dev_q, num_q};

    case (state_q)
      S_CLEAR: begin
        cnt_we_o = 1'b1;
        if (addr_q == LAST) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          dev_d               = device_i;
          num_d               = inode_number_i;
          slot_d              = slot_i;
          free_d              = 1'b0;
          res_d.read_request  = 1'b0;
          res_d.write_request = 1'b0;
          res_d.count         = '0;
          res_d.slot          = '0;
          if (kind_i == rist_pkg::KIND_ACQUIRE) begin
            if (inode_number_i == '0) begin
              res_d.status = rist_pkg::ST_ZERO;
              state_d      = S_DONE;
            end else begin
              raddr_o = '0;
              addr_d  = IW'(1);
              prev_d  = '0;
              state_d = S_SCAN;
            end
          end else if (!slot_given_i) begin
            res_d.status = rist_pkg::ST_BAD;
            state_d      = S_DONE;
          end else if (slot_oob) begin
            res_d.status = rist_pkg::ST_BAD;
            res_d.slot   = slot_i;
            state_d      = S_DONE;
          end else begin
            raddr_o = slot_addr;
            addr_d  = slot_addr;
            state_d = S_REL;
          end
        end
      end

      S_SCAN: begin
        prev_d = addr_q;
        if (addr_q != LAST) begin
          addr_d = addr_q + 1'b1;
        end
        if (cnt_rdata_i == '0) begin
          free_d     = 1'b1;
          free_idx_d = prev_q;
        end
        if (hit) begin
          cnt_we_o     = 1'b1;
          cnt_waddr_o  = prev_q;
          cnt_wdata_o  = cnt_inc;
          res_d.slot   = prev_ext[rist_pkg::SLOT_W-1:0];
          res_d.status = rist_pkg::ST_HIT;
          res_d.count  = cnt_inc;
          state_d      = S_DONE;
        end else if (prev_q == LAST) begin
          if (free_now) begin
            cnt_we_o           = 1'b1;
            cnt_waddr_o        = claim_idx;
            cnt_wdata_o        = rist_pkg::CNT_W'(1);
            key_we_o           = 1'b1;
            res_d.slot         = claim_ext[rist_pkg::SLOT_W-1:0];
            res_d.status       = rist_pkg::ST_CLAIMED;
            res_d.read_request = (dev_q != no_dev_i);
            res_d.count        = rist_pkg::CNT_W'(1);
          end else begin
            res_d.status = rist_pkg::ST_FULL;
          end
          state_d = S_DONE;
        end
      end

      S_REL: begin
        res_d.slot = slot_q;
        if (cnt_rdata_i == '0) begin
          res_d.status = rist_pkg::ST_WAS_FREE;
        end else begin
          cnt_we_o            = 1'b1;
          cnt_wdata_o         = cnt_dec;
          res_d.status        = rist_pkg::ST_RELEASED;
          res_d.write_request = (cnt_dec == '0);
          res_d.count         = cnt_dec;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q     <= prev_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    dev_q      <= dev_d;
    num_q      <= num_d;
    slot_q     <= slot_d;
    res_q      <= res_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule
`default_nettype wire

// ===== sv/refcounted_inode_slot_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_inode_slot_table_unit
// Reference-counted inode slot table with acquire and release beats.
// ----------------------------------------------------------------------------
// Counts live in one synchronous ram and device/number keys in another; one
// item is worked at a time. After reset a clearing pass zeroes every count,
// during which in_stall_o stays high (config writes are still taken). An
// acquire walks the rams one slot a cycle and ends early on a hit; a release
// does one read-modify-write of its slot; a zero number or a null or
// out-of-range release goes straight to its result. The result beat sits in
// an output register, so the next item is taken while it waits.
module refcounted_inode_slot_table_unit #(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [rist_pkg::DEV_W-1:0]  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        kind_i,
  input  wire logic [rist_pkg::DEV_W-1:0]  device_i,
  input  wire logic [rist_pkg::NUM_W-1:0]  inode_number_i,
  input  wire logic [rist_pkg::SLOT_W-1:0] slot_i,
  input  wire logic                        slot_given_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [rist_pkg::SLOT_W-1:0]      slot_out_o,
  output logic [2:0]                       status_o,
  output logic                             read_request_o,
  output logic                             write_request_o,
  output logic [rist_pkg::CNT_W-1:0]       count_after_o
);

  localparam int unsigned IW = $clog2(SLOT_COUNT);

  logic [rist_pkg::DEV_W-1:0] no_dev_q;
  logic                       out_valid_q, out_valid_d;
  rist_pkg::rist_result_t     out_q;

  logic                       res_valid;
  rist_pkg::rist_result_t     res;
  logic                       res_take;
  logic                       cnt_we;
  logic [IW-1:0]              cnt_waddr;
  logic [rist_pkg::CNT_W-1:0] cnt_wdata;
  logic [IW-1:0]              raddr;
  logic [rist_pkg::CNT_W-1:0] cnt_rdata;
  logic                       key_we;
  logic [rist_pkg::KEY_W-1:0] key_wdata;
  logic [rist_pkg::KEY_W-1:0] key_rdata;

  rist_ctrl #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .device_i      (device_i),
    .inode_number_i(inode_number_i),
    .slot_i        (slot_i),
    .slot_given_i  (slot_given_i),
    .no_dev_i      (no_dev_q),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_take_i    (res_take),
    .cnt_we_o      (cnt_we),
    .cnt_waddr_o   (cnt_waddr),
    .cnt_wdata_o   (cnt_wdata),
    .raddr_o       (raddr),
    .cnt_rdata_i   (cnt_rdata),
    .key_we_o      (key_we),
    .key_wdata_o   (key_wdata),
    .key_rdata_i   (key_rdata)
  );

  rist_ram #(
    .WIDTH(rist_pkg::CNT_W),
    .DEPTH(SLOT_COUNT)
  ) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .raddr_i(raddr),
    .rdata_o(cnt_rdata)
  );

  // keys share the write address of the count ram
  rist_ram #(
    .WIDTH(rist_pkg::KEY_W),
    .DEPTH(SLOT_COUNT)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(cnt_waddr),
    .wdata_i(key_wdata),
    .raddr_i(raddr),
    .rdata_o(key_rdata)
  );

  // output register frees when empty or when its beat leaves this cycle
  assign res_take = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      no_dev_q    <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        no_dev_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign slot_out_o      = out_q.slot;
  assign status_o        = out_q.status;
  assign read_request_o  = out_q.read_request;
  assign write_request_o = out_q.write_request;
  assign count_after_o   = out_q.count;

endmodule
`default_nettype wire

// ===== sv/rist_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rist_checker
// Port-level checks of the slot table, bound to the top level.
// ----------------------------------------------------------------------------
module rist_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [2:0]                  status_o,
  input wire logic                        read_request_o,
  input wire logic                        write_request_o,
  input wire logic [rist_pkg::CNT_W-1:0]  count_after_o
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(count_after_o))
    else $error("result beat changed while stalled");

  // a hit always leaves a live count and asks for no transfer
  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == rist_pkg::ST_HIT) |->
      (count_after_o != '0) && !read_request_o && !write_request_o)
    else $error("hit beat with bad count or request");

  // a write-back comes only from a release that dropped the count to zero
  a_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_request_o |->
      (status_o == rist_pkg::ST_RELEASED) && (count_after_o == '0))
    else $error("write request on wrong beat");

  // a read request only on a claim, which always starts at count one
  a_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_request_o |->
      (status_o == rist_pkg::ST_CLAIMED) && (count_after_o == 16'd1))
    else $error("read request on wrong beat");

endmodule

bind refcounted_inode_slot_table_unit rist_checker u_rist_checker (.*);
`default_nettype wire
